FILE: rtl/bpsd_pkg.sv
// Shared types, constants and helpers for the BMP pixel stream deframer.
package bpsd_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam logic [31:0] POS_OFFSET = 32'd10;
    localparam logic [31:0] POS_WIDTH  = 32'd18;
    localparam logic [31:0] POS_HEIGHT = 32'd22;
    localparam logic [31:0] POS_DEPTH  = 32'd28;
    localparam logic [31:0] POS_CHECK  = 32'd29;
    localparam logic [31:0] HDR_LEN    = 32'd30;

    localparam logic [15:0] DEPTH_24 = 16'd24;
    localparam logic [15:0] DEPTH_32 = 16'd32;

    localparam logic [23:0] LUMA_R     = 24'd19595;
    localparam logic [23:0] LUMA_G     = 24'd38470;
    localparam logic [23:0] LUMA_B     = 24'd7471;
    localparam logic [23:0] LUMA_ROUND = 24'd32768;

    localparam logic [31:0] SAT13_MAX = 32'd8191;

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_BAD_DEPTH = 2'd1,
        ST_BAD_SIZE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_ALPHA = 2'd3
    } pixel_phase_t;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  gray;
        logic [12:0] img_width;
        logic [12:0] img_height;
        status_t     status;
        logic        last;
    } result_t;

    function automatic logic [12:0] sat13(logic [31:0] v);
        logic [12:0] r;
        r = (v > SAT13_MAX) ? 13'h1FFF : v[12:0];
        return r;
    endfunction

    function automatic logic [31:0] put_byte(logic [31:0] v, logic [1:0] idx, logic [7:0] b);
        logic [31:0] r;
        r = v;
        unique case (idx)
            2'd0: r[7:0]   = b;
            2'd1: r[15:8]  = b;
            2'd2: r[23:16] = b;
            2'd3: r[31:24] = b;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/bpsd_parser.sv
// Header capture, pixel assembly and position tracking for one file byte per step.
module bpsd_parser #(
    parameter int MAX_DIM = bpsd_pkg::MAX_DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               mono,
    input  logic [7:0]         byte_in,
    input  logic               start_in,
    output logic               res_valid,
    output bpsd_pkg::result_t  res
);

    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [31:0]            pos_reg, pos_next, cur_pos;
    logic [31:0]            offset_reg, offset_next, cur_offset;
    logic [31:0]            width_reg, width_next, cur_width;
    logic [31:0]            height_reg, height_next, cur_height;
    logic [15:0]            depth_reg, depth_next, cur_depth;
    logic [CNT_W-1:0]       col_reg, col_next, cur_col;
    logic [CNT_W-1:0]       row_reg, row_next, cur_row;
    bpsd_pkg::pixel_phase_t phase_reg, phase_next, cur_phase;
    logic [1:0]             pad_reg, pad_next, cur_pad;
    logic [7:0]             blue_reg, blue_next, cur_blue;
    logic [7:0]             green_reg, green_next, cur_green;
    logic [23:0]            acc_reg, acc_next, cur_acc;
    logic                   halted_reg, halted_next, cur_halted;

    logic [31:0]            abs_h;
    logic [31:0]            start_pos;
    logic [15:0]            depth_new;
    logic [DIM_W-1:0]       w_n, h_n, col_ext, row_ext, col_plus, row_plus, row_sel;
    logic [DIM_W+11:0]      row_wide, col_wide;
    logic [23:0]            luma_sum;

    always_comb
    begin
        cur_pos    = start_in ? '0 : pos_reg;
        cur_offset = start_in ? '0 : offset_reg;
        cur_width  = start_in ? '0 : width_reg;
        cur_height = start_in ? '0 : height_reg;
        cur_depth  = start_in ? '0 : depth_reg;
        cur_col    = start_in ? '0 : col_reg;
        cur_row    = start_in ? '0 : row_reg;
        cur_phase  = start_in ? bpsd_pkg::PH_BLUE : phase_reg;
        cur_pad    = start_in ? '0 : pad_reg;
        cur_blue   = start_in ? '0 : blue_reg;
        cur_green  = start_in ? '0 : green_reg;
        cur_acc    = start_in ? '0 : acc_reg;
        cur_halted = start_in ? 1'b0 : halted_reg;

        abs_h     = cur_height[31] ? (32'd0 - cur_height) : cur_height;
        start_pos = (cur_offset < bpsd_pkg::HDR_LEN) ? bpsd_pkg::HDR_LEN : cur_offset;
        depth_new = {byte_in, cur_depth[7:0]};

        w_n      = cur_width[DIM_W-1:0];
        h_n      = abs_h[DIM_W-1:0];
        col_ext  = DIM_W'(cur_col);
        row_ext  = DIM_W'(cur_row);
        col_plus = col_ext + DIM_W'(1);
        row_plus = row_ext + DIM_W'(1);
        row_sel  = cur_height[31] ? row_ext : (h_n - DIM_W'(1) - row_ext);
        row_wide = {12'b0, row_sel};
        col_wide = {12'b0, col_ext};
        luma_sum = cur_acc + {16'b0, byte_in} * bpsd_pkg::LUMA_R + bpsd_pkg::LUMA_ROUND;

        pos_next    = cur_pos;
        offset_next = cur_offset;
        width_next  = cur_width;
        height_next = cur_height;
        depth_next  = cur_depth;
        col_next    = cur_col;
        row_next    = cur_row;
        phase_next  = cur_phase;
        pad_next    = cur_pad;
        blue_next   = cur_blue;
        green_next  = cur_green;
        acc_next    = cur_acc;
        halted_next = cur_halted;
        res_valid   = 1'b0;
        res         = '0;

        if (!cur_halted)
        begin
            pos_next = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;
            if (cur_pos < bpsd_pkg::HDR_LEN)
            begin
                if (cur_pos >= bpsd_pkg::POS_OFFSET && cur_pos < bpsd_pkg::POS_OFFSET + 32'd4)
                begin
                    offset_next = bpsd_pkg::put_byte(cur_offset,
                        2'(cur_pos - bpsd_pkg::POS_OFFSET), byte_in);
                end
                else if (cur_pos >= bpsd_pkg::POS_WIDTH && cur_pos < bpsd_pkg::POS_WIDTH + 32'd4)
                begin
                    width_next = bpsd_pkg::put_byte(cur_width,
                        2'(cur_pos - bpsd_pkg::POS_WIDTH), byte_in);
                end
                else if (cur_pos >= bpsd_pkg::POS_HEIGHT && cur_pos < bpsd_pkg::POS_HEIGHT + 32'd4)
                begin
                    height_next = bpsd_pkg::put_byte(cur_height,
                        2'(cur_pos - bpsd_pkg::POS_HEIGHT), byte_in);
                end
                else if (cur_pos == bpsd_pkg::POS_DEPTH)
                begin
                    depth_next = {cur_depth[15:8], byte_in};
                end
                else if (cur_pos == bpsd_pkg::POS_CHECK)
                begin
                    depth_next = depth_new;
                end

                if (cur_pos == bpsd_pkg::POS_CHECK)
                begin
                    res.img_width  = (cur_width[31] || cur_width == 32'd0) ? 13'd0
                                     : bpsd_pkg::sat13(cur_width);
                    res.img_height = bpsd_pkg::sat13(abs_h);
                    if (depth_new != bpsd_pkg::DEPTH_24 && depth_new != bpsd_pkg::DEPTH_32)
                    begin
                        res.status  = bpsd_pkg::ST_BAD_DEPTH;
                        res_valid   = 1'b1;
                        halted_next = 1'b1;
                    end
                    else if (cur_width[31] || cur_width == 32'd0 || cur_width > 32'(MAX_DIM)
                             || abs_h == 32'd0 || abs_h > 32'(MAX_DIM))
                    begin
                        res.status  = bpsd_pkg::ST_BAD_SIZE;
                        res_valid   = 1'b1;
                        halted_next = 1'b1;
                    end
                end
            end
            else if (cur_pos >= start_pos)
            begin
                priority if (cur_phase == bpsd_pkg::PH_ALPHA)
                begin
                    phase_next = bpsd_pkg::PH_BLUE;
                end
                else if (cur_pad != 2'd0)
                begin
                    pad_next = cur_pad - 2'd1;
                end
                else if (cur_phase == bpsd_pkg::PH_BLUE)
                begin
                    blue_next  = byte_in;
                    acc_next   = {16'b0, byte_in} * bpsd_pkg::LUMA_B;
                    phase_next = bpsd_pkg::PH_GREEN;
                end
                else if (cur_phase == bpsd_pkg::PH_GREEN)
                begin
                    green_next = byte_in;
                    acc_next   = cur_acc + {16'b0, byte_in} * bpsd_pkg::LUMA_G;
                    phase_next = bpsd_pkg::PH_RED;
                end
                else
                begin
                    res_valid      = 1'b1;
                    res.row        = row_wide[11:0];
                    res.col        = col_wide[11:0];
                    res.img_width  = bpsd_pkg::sat13(cur_width);
                    res.img_height = bpsd_pkg::sat13(abs_h);
                    res.status     = bpsd_pkg::ST_PIXEL;
                    if (mono)
                    begin
                        res.gray = luma_sum[23:16];
                    end
                    else
                    begin
                        res.red   = byte_in;
                        res.green = cur_green;
                        res.blue  = cur_blue;
                    end
                    phase_next = (cur_depth == bpsd_pkg::DEPTH_32) ? bpsd_pkg::PH_ALPHA
                                 : bpsd_pkg::PH_BLUE;
                    if (col_plus >= w_n)
                    begin
                        col_next = '0;
                        // Row padding to a 4-byte multiple equals the width modulo four.
                        if (cur_depth == bpsd_pkg::DEPTH_24)
                        begin
                            pad_next = cur_width[1:0];
                        end
                        if (row_plus >= h_n)
                        begin
                            res.last    = 1'b1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            row_next = cur_row + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = cur_col + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            phase_reg  <= bpsd_pkg::PH_BLUE;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            acc_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            phase_reg  <= phase_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: rtl/bmp_pixel_stream_deframer.sv
// Top level of the BMP pixel stream deframer with stream ports and output register.
// A taken byte goes to the input register, its result to the output register.
// Throughput: one byte per cycle, one parser step each, unless m_tready stalls.
// The mono luma product is accumulated over the blue, green and red bytes of a pixel.
// Reset clears the parser, the mode register and both stages; parsing starts as a new file.
module bmp_pixel_stream_deframer #(
    parameter int MAX_DIM = bpsd_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic [0:0]  s_tuser,    // file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // out_row, out_col, red, green, blue, gray,
                                    // image_width, image_height, zero fill
    output logic [1:0]  m_tuser,    // status
    output logic        m_tlast,    // last_pixel
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data // mono_mode
);

    logic              mono_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_start_reg;
    logic              out_valid_reg;
    bpsd_pkg::result_t out_res_reg;
    logic              out_free;
    logic              advance;
    logic              res_valid;
    bpsd_pkg::result_t res;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    bpsd_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .mono      (mono_reg),
        .byte_in   (in_byte_reg),
        .start_in  (in_start_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mono_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.img_height, out_res_reg.img_width,
                       out_res_reg.gray, out_res_reg.blue, out_res_reg.green,
                       out_res_reg.red, out_res_reg.col, out_res_reg.row};
    assign m_tuser  = out_res_reg.status;
    assign m_tlast  = out_res_reg.last;

    a_error_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != bpsd_pkg::ST_PIXEL |-> !m_tlast)
        else $error("Error result marked as last pixel.");

    a_error_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != bpsd_pkg::ST_PIXEL |-> m_tdata[55:0] == 56'd0)
        else $error("Error result carries position or colour.");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg)
                                      && $stable(in_start_reg))
        else $error("Input stage lost a request under stall.");

    a_not_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("Input refused while a stage is free.");

endmodule

FILE: tb/bmp_pixel_stream_deframer_tb.sv
// Testbench for the BMP pixel stream deframer: file byte streams in, predicted pixels and error reports checked.
`timescale 1ns / 100ps

module bmp_pixel_stream_deframer_tb;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned MAX_DIM = bpsd_pkg::MAX_DIM_DEF;
    localparam int unsigned RANDOM_STOP = 1800;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic        cfg_wr_data;

    bmp_pixel_stream_deframer uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    bpsd_pkg::result_t      pending_reports[$];
    int unsigned            errors;
    int unsigned            cycles;
    int unsigned            sent_bytes;
    int unsigned            rx_hold;
    bit                     idle_on;
    fill_t                  fill_mode;

    bit                     mono_sel;
    bit [31:0]              byte_pos;
    bit [31:0]              pix_offset;
    bit [31:0]              hdr_width;
    bit [31:0]              hdr_height;
    bit [15:0]              hdr_depth;
    bit [11:0]              col_idx;
    bit [11:0]              row_idx;
    bpsd_pkg::pixel_phase_t phase;
    bit [1:0]               pad_left;
    bit [7:0]               blue_hold;
    bit [7:0]               green_hold;
    bit                     stopped;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit [12:0] clip13(bit [31:0] v);
        return (v > 32'd8191) ? 13'h1FFF : v[12:0];
    endfunction

    function automatic bit [31:0] abs_of(bit [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    function automatic void clear_parser();
        byte_pos = 0;
        pix_offset = 0;
        hdr_width = 0;
        hdr_height = 0;
        hdr_depth = 0;
        col_idx = 0;
        row_idx = 0;
        phase = bpsd_pkg::PH_BLUE;
        pad_left = 0;
        blue_hold = 0;
        green_hold = 0;
        stopped = 0;
    endfunction

    // Advances the parser copy by one file byte; returns 1 when the byte yields a result.
    function automatic bit decode_byte(input bit [7:0] b, input bit fs,
                                       output bpsd_pkg::result_t r);
        bit [31:0]         p;
        bit [31:0]         hh;
        bit [31:0]         first;
        bit [31:0]         y;
        bpsd_pkg::status_t st;
        r = '0;
        if (fs)
            clear_parser();
        if (stopped)
            return 0;
        p = byte_pos;
        if (byte_pos != 32'hFFFF_FFFF)
            byte_pos++;
        if (p < bpsd_pkg::HDR_LEN)
        begin
            if (p >= bpsd_pkg::POS_OFFSET && p < bpsd_pkg::POS_OFFSET + 4)
                pix_offset[8 * (p - bpsd_pkg::POS_OFFSET) +: 8] = b;
            else if (p >= bpsd_pkg::POS_WIDTH && p < bpsd_pkg::POS_WIDTH + 4)
                hdr_width[8 * (p - bpsd_pkg::POS_WIDTH) +: 8] = b;
            else if (p >= bpsd_pkg::POS_HEIGHT && p < bpsd_pkg::POS_HEIGHT + 4)
                hdr_height[8 * (p - bpsd_pkg::POS_HEIGHT) +: 8] = b;
            else if (p >= bpsd_pkg::POS_DEPTH)
                hdr_depth[8 * (p - bpsd_pkg::POS_DEPTH) +: 8] = b;
            if (p == bpsd_pkg::POS_CHECK)
            begin
                hh = abs_of(hdr_height);
                st = bpsd_pkg::ST_PIXEL;
                if (hdr_depth != bpsd_pkg::DEPTH_24 && hdr_depth != bpsd_pkg::DEPTH_32)
                    st = bpsd_pkg::ST_BAD_DEPTH;
                else if (hdr_width[31] || hdr_width == 0 || hdr_width > MAX_DIM ||
                         hh == 0 || hh > MAX_DIM)
                    st = bpsd_pkg::ST_BAD_SIZE;
                if (st != bpsd_pkg::ST_PIXEL)
                begin
                    r.img_width = (hdr_width[31] || hdr_width == 0) ? 13'd0
                                  : clip13(hdr_width);
                    r.img_height = clip13(hh);
                    r.status = st;
                    stopped = 1;
                    return 1;
                end
            end
            return 0;
        end
        first = (pix_offset < bpsd_pkg::HDR_LEN) ? bpsd_pkg::HDR_LEN : pix_offset;
        if (p < first)
            return 0;
        if (phase == bpsd_pkg::PH_ALPHA)
        begin
            phase = bpsd_pkg::PH_BLUE;
            return 0;
        end
        if (pad_left != 0)
        begin
            pad_left--;
            return 0;
        end
        if (phase == bpsd_pkg::PH_BLUE)
        begin
            blue_hold = b;
            phase = bpsd_pkg::PH_GREEN;
            return 0;
        end
        if (phase == bpsd_pkg::PH_GREEN)
        begin
            green_hold = b;
            phase = bpsd_pkg::PH_RED;
            return 0;
        end
        hh = abs_of(hdr_height);
        r.row = hdr_height[31] ? row_idx : 12'(hh - 32'd1 - row_idx);
        r.col = col_idx;
        if (mono_sel)
        begin
            y = (32'd19595 * b + 32'd38470 * green_hold + 32'd7471 * blue_hold
                 + 32'd32768) >> 16;
            r.gray = y[7:0];
        end
        else
        begin
            r.red = b;
            r.green = green_hold;
            r.blue = blue_hold;
        end
        r.img_width = clip13(hdr_width);
        r.img_height = clip13(hh);
        r.status = bpsd_pkg::ST_PIXEL;
        if (hdr_depth == bpsd_pkg::DEPTH_32)
            phase = bpsd_pkg::PH_ALPHA;
        else
            phase = bpsd_pkg::PH_BLUE;
        if (32'(col_idx) + 32'd1 >= hdr_width)
        begin
            col_idx = 0;
            if (hdr_depth == bpsd_pkg::DEPTH_24)
                pad_left = 2'((32'd4 - ((32'd3 * (hdr_width & 32'd3)) & 32'd3)) & 32'd3);
            if (32'(row_idx) + 32'd1 >= hh)
            begin
                r.last = 1'b1;
                stopped = 1;
            end
            else
                row_idx++;
        end
        else
            col_idx++;
        return 1;
    endfunction

    function automatic bit [7:0] fill_byte();
        case (fill_mode)
            FILL_ONES:  return 8'hFF;
            FILL_ZEROS: return 8'h00;
            default:    return 8'($urandom);
        endcase
    endfunction

    function automatic int unsigned body_length(bit [31:0] off, bit [31:0] w, bit [31:0] h,
                                                bit [15:0] d);
        int unsigned first;
        int unsigned row_bytes;
        first = (off > bpsd_pkg::HDR_LEN) ? off - bpsd_pkg::HDR_LEN : 0;
        row_bytes = w * (d / 8);
        if (d == bpsd_pkg::DEPTH_24)
            row_bytes += (4 - (row_bytes % 4)) % 4;
        return first + row_bytes * abs_of(h);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        bpsd_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with no request pending: tdata %h status %0d", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("out_row", 32'(want.row), 32'(m_tdata[11:0]));
                check_field("out_col", 32'(want.col), 32'(m_tdata[23:12]));
                check_field("red", 32'(want.red), 32'(m_tdata[31:24]));
                check_field("green", 32'(want.green), 32'(m_tdata[39:32]));
                check_field("blue", 32'(want.blue), 32'(m_tdata[47:40]));
                check_field("gray", 32'(want.gray), 32'(m_tdata[55:48]));
                check_field("image_width", 32'(want.img_width), 32'(m_tdata[68:56]));
                check_field("image_height", 32'(want.img_height), 32'(m_tdata[81:69]));
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("last_pixel", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_hold <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic push_byte(bit [7:0] b, bit fs);
        int unsigned       gap;
        bpsd_pkg::result_t r;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_bytes++;
        if (decode_byte(b, fs, r))
            pending_reports.push_back(r);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic set_mono(bit v);
        wait_drain();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mono_sel = v;
    endtask

    task automatic send_bmp(bit [31:0] off, bit [31:0] w, bit [31:0] h, bit [15:0] d,
                            int unsigned body, bit fs);
        bit [7:0] v;
        for (int i = 0; i < bpsd_pkg::HDR_LEN; i++)
        begin
            v = 8'($urandom);
            if (i >= bpsd_pkg::POS_OFFSET && i < bpsd_pkg::POS_OFFSET + 4)
                v = off[8 * (i - bpsd_pkg::POS_OFFSET) +: 8];
            else if (i >= bpsd_pkg::POS_WIDTH && i < bpsd_pkg::POS_WIDTH + 4)
                v = w[8 * (i - bpsd_pkg::POS_WIDTH) +: 8];
            else if (i >= bpsd_pkg::POS_HEIGHT && i < bpsd_pkg::POS_HEIGHT + 4)
                v = h[8 * (i - bpsd_pkg::POS_HEIGHT) +: 8];
            else if (i >= bpsd_pkg::POS_DEPTH)
                v = d[8 * (i - bpsd_pkg::POS_DEPTH) +: 8];
            push_byte(v, (i == 0) ? fs : 1'b0);
        end
        for (int unsigned i = 0; i < body; i++)
            push_byte(fill_byte(), 1'b0);
    endtask

    task automatic send_good(bit [31:0] off, bit [31:0] w, bit [31:0] h, bit [15:0] d);
        send_bmp(off, w, h, d, body_length(off, w, h, d), 1'b1);
    endtask

    task automatic send_random_file();
        bit [31:0]   off;
        bit [31:0]   w;
        bit [31:0]   h;
        bit [15:0]   d;
        int unsigned kind;
        int unsigned mag;
        int unsigned body;
        kind = $urandom_range(0, 11);
        d = $urandom_range(0, 1) ? bpsd_pkg::DEPTH_32 : bpsd_pkg::DEPTH_24;
        w = $urandom_range(1, 6);
        mag = $urandom_range(1, 4);
        h = $urandom_range(0, 1) ? 32'd0 - mag : mag;
        off = $urandom_range(0, 44);
        if (kind == 0)
        begin
            d = 16'($urandom);
            if (d == bpsd_pkg::DEPTH_24 || d == bpsd_pkg::DEPTH_32)
                d = 16'd8;
            off = $urandom;
        end
        else if (kind == 1)
        begin
            off = $urandom;
            case ($urandom_range(0, 6))
                0: w = 0;
                1: w = $urandom | 32'h8000_0000;
                2: w = $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
                3: h = 0;
                4: h = 32'd0 - $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
                5: h = 32'h8000_0000;
                default: h = $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
            endcase
        end
        if (kind <= 1)
            body = $urandom_range(0, 3);
        else
        begin
            body = body_length(off, w, h, d);
            if (kind == 2)
                body = $urandom_range(0, body);
            else
                body += $urandom_range(0, 2);
        end
        send_bmp(off, w, h, d, body, $urandom_range(0, 15) != 0);
    endtask

    task automatic test_headerless_start();
        send_bmp(54, 2, 2, bpsd_pkg::DEPTH_24, body_length(54, 2, 2, bpsd_pkg::DEPTH_24), 1'b0);
    endtask

    task automatic test_row_padding();
        for (int unsigned w = 1; w <= 4; w++)
        begin
            send_good(30, w, 2, bpsd_pkg::DEPTH_24);
            send_good(0, w, 32'd0 - 32'd2, bpsd_pkg::DEPTH_24);
        end
    endtask

    task automatic test_pixel_extremes();
        fill_mode = FILL_ONES;
        send_good(30, 2, 32'd0 - 32'd1, bpsd_pkg::DEPTH_24);
        fill_mode = FILL_ZEROS;
        send_good(30, 2, 1, bpsd_pkg::DEPTH_24);
        set_mono(1'b1);
        send_good(30, 2, 1, bpsd_pkg::DEPTH_32);
        fill_mode = FILL_ONES;
        send_good(30, 2, 32'd0 - 32'd1, bpsd_pkg::DEPTH_24);
        fill_mode = FILL_RANDOM;
        send_good(33, 3, 2, bpsd_pkg::DEPTH_24);
    endtask

    task automatic test_alpha_bytes();
        send_good(40, 3, 3, bpsd_pkg::DEPTH_32);
        set_mono(1'b0);
        send_good(12, 3, 32'd0 - 32'd2, bpsd_pkg::DEPTH_32);
    endtask

    task automatic test_header_errors();
        bit [15:0] bad_depths[6] = '{16'd0, 16'd8, 16'd16, 16'd31, 16'd33, 16'hFFFF};
        foreach (bad_depths[i])
            send_bmp(54, 2, 2, bad_depths[i], 3, 1'b1);
        send_bmp(54, 0, 2, 16'd8, 3, 1'b1);
        send_bmp(54, 0, 2, bpsd_pkg::DEPTH_24, 3, 1'b1);
        send_bmp(54, 32'hFFFF_FFFB, 2, bpsd_pkg::DEPTH_24, 3, 1'b1);
        send_bmp(54, MAX_DIM + 1, 2, bpsd_pkg::DEPTH_32, 3, 1'b1);
        send_bmp(54, 20000, 2, bpsd_pkg::DEPTH_24, 3, 1'b1);
        send_bmp(54, 2, 0, bpsd_pkg::DEPTH_24, 3, 1'b1);
        send_bmp(54, 2, MAX_DIM + 1, bpsd_pkg::DEPTH_24, 3, 1'b1);
        send_bmp(54, 2, 32'd0 - (MAX_DIM + 1), bpsd_pkg::DEPTH_32, 3, 1'b1);
        send_bmp(54, 2, 32'h8000_0000, bpsd_pkg::DEPTH_24, 3, 1'b1);
    endtask

    task automatic test_restart();
        for (int i = 0; i < 15; i++)
            push_byte(8'($urandom), i == 0);
        send_good(30, 3, 2, bpsd_pkg::DEPTH_24);
        send_bmp(36, 4, 3, bpsd_pkg::DEPTH_24, body_length(36, 4, 3, bpsd_pkg::DEPTH_24) / 2,
                 1'b1);
        send_good(31, 2, 32'd0 - 32'd3, bpsd_pkg::DEPTH_32);
    endtask

    // The largest images are only started; a few pixels show the header is taken.
    task automatic test_largest_sizes();
        set_mono(1'b1);
        send_bmp(54, MAX_DIM, 1, bpsd_pkg::DEPTH_24, 24 + 3 * 8, 1'b1);
        set_mono(1'b0);
        send_bmp(30, 1, MAX_DIM, bpsd_pkg::DEPTH_32, 4 * 8, 1'b1);
    endtask

    task automatic test_random_files();
        while (sent_bytes < RANDOM_STOP)
        begin
            if ($urandom_range(0, 4) == 0)
                set_mono(1'($urandom_range(0, 1)));
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_file();
        end
    endtask

    task automatic test_quiet_finish();
        idle_on = 1'b0;
        set_mono(1'b1);
        for (int i = 0; i < 3; i++)
            send_random_file();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        errors = 0;
        cycles = 0;
        sent_bytes = 0;
        rx_hold = 0;
        idle_on = 1'b1;
        fill_mode = FILL_RANDOM;
        mono_sel = 1'b0;
        clear_parser();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_headerless_start();
        test_row_padding();
        test_pixel_extremes();
        test_alpha_bytes();
        test_header_errors();
        test_restart();
        test_largest_sizes();
        test_random_files();
        test_quiet_finish();

        wait_drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
